// File: rtl/core/text_console_char_writer_assert.svh
// assertion macros shared by the console writer checks
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH

// same-cycle implication, disabled while rst is high
`define TCW_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("console writer check failed");

// next-cycle implication, disabled while rst is high
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("console writer check failed");

`endif

// File: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types, constants and codes shared by the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // geometry
   localparam int ADDR_W       = 14;
   localparam int CELLS_W      = 15;
   localparam int LINE_WIDTH   = 80;
   localparam int SCREEN_CELLS = 2000;
   // wide enough for base + cells and view start + screen without wrap
   localparam int CMP_W        = ADDR_W + 3;

   // reciprocal for the newline line-start search
   localparam int RECIP        = (1 << ADDR_W) / LINE_WIDTH;
   localparam int RECIP_W      = $clog2(RECIP + 1);
   localparam int PROD_W       = ADDR_W + RECIP_W;

   // character codes
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_SPACE     = 8'd32;

   // register reset values
   localparam logic [ADDR_W-1:0]  BASE_RESET  = '0;
   localparam logic [CELLS_W-1:0] CELLS_RESET = 15'd4000;
   localparam logic [7:0]         ATTR_RESET  = 8'd7;

   typedef enum logic [1:0] {
      CMD_PUT  = 2'd0,
      CMD_BACK = 2'd1,
      CMD_FWD  = 2'd2,
      CMD_HOME = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_WINDOW_BASE    = 2'd0,
      CSR_WINDOW_CELLS   = 2'd1,
      CSR_CHAR_ATTRIBUTE = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_NL_REM,
      ST_NL_SET,
      ST_FOLLOW,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_PUT,
      DP_BACK,
      DP_FWD,
      DP_HOME,
      DP_NL_MUL,
      DP_NL_REM,
      DP_NL_SET,
      DP_FOLLOW,
      DP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic              cell_write;
      logic [ADDR_W-1:0] cell_address;
      logic [7:0]        cell_char;
      logic [7:0]        cell_attr;
      logic [ADDR_W-1:0] cursor_cell;
      logic [ADDR_W-1:0] view_start;
   } rsp_type;

   // datapath status seen by the controller
   typedef struct packed {
      logic [1:0] command;
      logic       is_newline;
      logic       nl_room;
      logic       follow_more;
   } status_type;

endpackage

// File: rtl/core/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the console writer: steps each word through decode, the
// newline line-start search, the view follow loop and the result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tcw_pkg::status_type  status,
   output tcw_pkg::dp_op_type   dp_op
);

   tcw_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;
   logic publish;

   // state and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state and datapath command
   always_comb begin
      state_in  = state_ff;
      dp_op     = tcw_pkg::DP_NOP;
      req_ready = 1'b0;
      publish   = 1'b0;
      unique case (state_ff)
         tcw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_op    = tcw_pkg::DP_LOAD;
               state_in = tcw_pkg::ST_EXEC;
            end
         end
         tcw_pkg::ST_EXEC: begin
            unique case (status.command)
               tcw_pkg::CMD_PUT: begin
                  if (status.is_newline && status.nl_room) begin
                     dp_op    = tcw_pkg::DP_NL_MUL;
                     state_in = tcw_pkg::ST_NL_REM;
                  end else begin
                     dp_op    = tcw_pkg::DP_PUT;
                     state_in = tcw_pkg::ST_FOLLOW;
                  end
               end
               tcw_pkg::CMD_BACK: begin
                  dp_op    = tcw_pkg::DP_BACK;
                  state_in = tcw_pkg::ST_FINISH;
               end
               tcw_pkg::CMD_FWD: begin
                  dp_op    = tcw_pkg::DP_FWD;
                  state_in = tcw_pkg::ST_FINISH;
               end
               default: begin
                  dp_op    = tcw_pkg::DP_HOME;
                  state_in = tcw_pkg::ST_FINISH;
               end
            endcase
         end
         tcw_pkg::ST_NL_REM: begin
            dp_op    = tcw_pkg::DP_NL_REM;
            state_in = tcw_pkg::ST_NL_SET;
         end
         tcw_pkg::ST_NL_SET: begin
            dp_op    = tcw_pkg::DP_NL_SET;
            state_in = tcw_pkg::ST_FOLLOW;
         end
         tcw_pkg::ST_FOLLOW: begin
            // one line of view advance per cycle
            if (status.follow_more) begin
               dp_op = tcw_pkg::DP_FOLLOW;
            end else if (slot_free) begin
               dp_op    = tcw_pkg::DP_PUBLISH;
               publish  = 1'b1;
               state_in = tcw_pkg::ST_IDLE;
            end else begin
               state_in = tcw_pkg::ST_FINISH;
            end
         end
         tcw_pkg::ST_FINISH: begin
            if (slot_free) begin
               dp_op    = tcw_pkg::DP_PUBLISH;
               publish  = 1'b1;
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   // result valid: set on publish, cleared when taken
   always_comb begin
      if (publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/core/tcw_dpath.sv
// ----------------------------------------------------------------------------
// tcw_dpath
// Datapath of the console writer: window registers, cursor and view start,
// the newline line-start search by reciprocal multiply and the result
// register.
// ----------------------------------------------------------------------------
module tcw_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [1:0]                 csr_index,
   input  logic [tcw_pkg::CELLS_W-1:0] csr_wdata,
   input  tcw_pkg::req_type           req_data,
   input  tcw_pkg::dp_op_type         dp_op,
   output tcw_pkg::status_type        status,
   output tcw_pkg::rsp_type           rsp_data
);

   localparam int AW = tcw_pkg::ADDR_W;
   localparam int CW = tcw_pkg::CMP_W;
   localparam logic [CW-1:0] LW_C = CW'(tcw_pkg::LINE_WIDTH);
   localparam logic [CW-1:0] SC_C = CW'(tcw_pkg::SCREEN_CELLS);
   localparam logic [AW-1:0] LW_A = AW'(tcw_pkg::LINE_WIDTH);
   localparam logic [tcw_pkg::RECIP_W-1:0] RECIP_C = tcw_pkg::RECIP_W'(tcw_pkg::RECIP);

   // configuration
   logic [AW-1:0]               base_ff, base_in;
   logic [tcw_pkg::CELLS_W-1:0] cells_ff, cells_in;
   logic [7:0]                  attr_ff, attr_in;
   // console state
   logic [AW-1:0]               cursor_ff, cursor_in;
   logic [CW-1:0]               ds_ff, ds_in;
   // current word
   logic [1:0]                  cmd_ff, cmd_in;
   logic [7:0]                  char_ff, char_in;
   logic                        wr_ff, wr_in;
   logic [AW-1:0]               waddr_ff, waddr_in;
   logic [7:0]                  wchar_ff, wchar_in;
   logic [7:0]                  wattr_ff, wattr_in;
   // newline search
   logic [AW-1:0]               off_ff, off_in;
   logic [tcw_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [AW-1:0]               rem_ff, rem_in;
   // result register
   tcw_pkg::rsp_type            rsp_ff, rsp_in;

   logic [CW-1:0]               base_w, end_w, cur_w, ds_scr;
   logic [AW-1:0]               off_c, rem_fix, cur_dec, cur_inc;
   logic [CW-1:0]               qxl, nc, ds_fwd;
   logic [tcw_pkg::RECIP_W-1:0] q_est;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= tcw_pkg::BASE_RESET;
         cells_ff  <= tcw_pkg::CELLS_RESET;
         attr_ff   <= tcw_pkg::ATTR_RESET;
         cursor_ff <= '0;
         ds_ff     <= '0;
      end else begin
         base_ff   <= base_in;
         cells_ff  <= cells_in;
         attr_ff   <= attr_in;
         cursor_ff <= cursor_in;
         ds_ff     <= ds_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      char_ff  <= char_in;
      wr_ff    <= wr_in;
      waddr_ff <= waddr_in;
      wchar_ff <= wchar_in;
      wattr_ff <= wattr_in;
      off_ff   <= off_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      rsp_ff   <= rsp_in;
   end

   // wide views for the compares
   assign base_w  = CW'(base_ff);
   assign end_w   = base_w + CW'(cells_ff);
   assign cur_w   = CW'(cursor_ff);
   assign ds_scr  = ds_ff + SC_C;
   assign off_c   = (cursor_ff >= base_ff) ? (cursor_ff - base_ff) : '0;
   assign cur_dec = cursor_ff - AW'(1);
   assign cur_inc = cursor_ff + AW'(1);
   assign ds_fwd  = ds_ff + LW_C;

   // line-start search: estimate is the quotient or one below it
   assign q_est   = prod_ff[tcw_pkg::PROD_W-1:AW];
   assign qxl     = CW'(q_est) * LW_C;
   assign rem_fix = (rem_ff >= LW_A) ? (rem_ff - LW_A) : rem_ff;
   assign nc      = base_w + CW'(off_ff) - CW'(rem_fix) + LW_C;

   // status towards the sequencer
   assign status.command     = cmd_ff;
   assign status.is_newline  = (char_ff == tcw_pkg::CH_NEWLINE);
   assign status.nl_room     = (cur_w + LW_C) < end_w;
   assign status.follow_more = (cur_w >= ds_scr) && (ds_scr < end_w);

   // configuration writes
   always_comb begin
      base_in  = base_ff;
      cells_in = cells_ff;
      attr_in  = attr_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            tcw_pkg::CSR_WINDOW_BASE:    base_in  = csr_wdata[AW-1:0];
            tcw_pkg::CSR_WINDOW_CELLS:   cells_in = csr_wdata;
            tcw_pkg::CSR_CHAR_ATTRIBUTE: attr_in  = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // operations
   always_comb begin
      cursor_in = cursor_ff;
      ds_in     = ds_ff;
      cmd_in    = cmd_ff;
      char_in   = char_ff;
      wr_in     = wr_ff;
      waddr_in  = waddr_ff;
      wchar_in  = wchar_ff;
      wattr_in  = wattr_ff;
      off_in    = off_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      rsp_in    = rsp_ff;
      unique case (dp_op)
         tcw_pkg::DP_NOP: ;
         tcw_pkg::DP_LOAD: begin
            cmd_in   = req_data.command;
            char_in  = req_data.char_code;
            wr_in    = 1'b0;
            waddr_in = '0;
            wchar_in = '0;
            wattr_in = '0;
         end
         tcw_pkg::DP_PUT: begin
            if (char_ff == tcw_pkg::CH_BACKSPACE) begin
               if (cursor_ff > base_ff) begin
                  cursor_in = cur_dec;
                  wr_in     = 1'b1;
                  waddr_in  = cur_dec;
                  wchar_in  = tcw_pkg::CH_SPACE;
                  wattr_in  = attr_ff;
               end
            end else if (char_ff != tcw_pkg::CH_NEWLINE) begin
               if ((cur_w + CW'(1)) < end_w) begin
                  cursor_in = cur_inc;
                  wr_in     = 1'b1;
                  waddr_in  = cursor_ff;
                  wchar_in  = char_ff;
                  wattr_in  = attr_ff;
               end
            end
         end
         tcw_pkg::DP_BACK: begin
            if (ds_ff > base_w) begin
               ds_in = (ds_ff >= base_w + LW_C) ? (ds_ff - LW_C) : base_w;
            end
         end
         tcw_pkg::DP_FWD: begin
            if (ds_scr < end_w) begin
               ds_in = CW'(ds_fwd[AW-1:0]);
            end
         end
         tcw_pkg::DP_HOME: begin
            cursor_in = base_ff;
            ds_in     = base_w;
         end
         tcw_pkg::DP_NL_MUL: begin
            off_in  = off_c;
            prod_in = off_c * RECIP_C;
         end
         tcw_pkg::DP_NL_REM: begin
            rem_in = off_ff - qxl[AW-1:0];
         end
         tcw_pkg::DP_NL_SET: begin
            cursor_in = nc[AW-1:0];
         end
         tcw_pkg::DP_FOLLOW: begin
            ds_in = ds_fwd;
         end
         tcw_pkg::DP_PUBLISH: begin
            ds_in               = CW'(ds_ff[AW-1:0]);
            rsp_in.cell_write   = wr_ff;
            rsp_in.cell_address = waddr_ff;
            rsp_in.cell_char    = wchar_ff;
            rsp_in.cell_attr    = wattr_ff;
            rsp_in.cursor_cell  = cursor_ff;
            rsp_in.view_start   = ds_ff[AW-1:0];
         end
         default: ;
      endcase
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/core/text_console_char_writer.sv
// From accept to result valid, a printable byte, backspace, a newline on the
// last line, scroll or home pass decode, then the follow or finish state; a
// newline that moves the cursor adds the remainder and line-set states; the
// follow state advances the view start a line at a time to follow it. The
// next word is taken while the previous result waits in the output register.
// Reset (synchronous, active high) restores window registers, cursor and view.
// ----------------------------------------------------------------------------
// text_console_char_writer
// Cursor and display-start keeper for one text-mode console window, giving
// the video cell write and CRT cursor/start values for every word.
// ----------------------------------------------------------------------------
module text_console_char_writer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic [1:0]                  csr_index,
   input  logic [tcw_pkg::CELLS_W-1:0] csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  tcw_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output tcw_pkg::rsp_type            rsp_data
);

   tcw_pkg::status_type status;
   tcw_pkg::dp_op_type  dp_op;

   // sequencer
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .dp_op     (dp_op)
   );

   // datapath
   tcw_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_data     (req_data),
      .dp_op        (dp_op),
      .status       (status),
      .rsp_data     (rsp_data)
   );

endmodule

// File: rtl/core/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the console writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_char_writer_assert.svh"

module tcw_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input tcw_pkg::rsp_type            rsp_data
);

   logic rsp_stall;
   logic cells_zero;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign cells_zero = (rsp_data.cell_address == '0) && (rsp_data.cell_char == '0)
                       && (rsp_data.cell_attr == '0);

   // a stalled result holds
   `TCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   // a result without a cell write carries zero cell fields
   `TCW_ASSERT_NOW(a_no_write_zero, clock, reset, rsp_valid && !rsp_data.cell_write, cells_zero)

   // one word in work at a time
   `TCW_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // no result straight out of reset
   `TCW_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind text_console_char_writer tcw_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: bench/text_console_char_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_tb
// Self-checking bench for the console writer. Puts, scrolls and homes are
// driven over the request channel, and a local cursor/view predictor works
// out each expected response. Results are checked field by field as they
// leave the block. Directed edge cases come first, then random traffic over
// many window settings, with random idling on both sides and a long
// response hold-off.
// ----------------------------------------------------------------------------
module text_console_char_writer_tb;

   localparam int          CYCLE_LIMIT = 1_500_000;
   localparam int          HOLD_CYCLES = 80;
   localparam int          SETTLE      = 8;
   localparam int unsigned ADDR_MASK   = (1 << tcw_pkg::ADDR_W) - 1;

   logic                        clock;
   logic                        reset;
   logic                        csr_write_en;
   logic [1:0]                  csr_index;
   logic [tcw_pkg::CELLS_W-1:0] csr_wdata;
   logic                        req_valid;
   logic                        req_ready;
   tcw_pkg::req_type            req_data;
   logic                        rsp_valid;
   logic                        rsp_ready;
   tcw_pkg::rsp_type            rsp_data;

   // predictor copy of the window registers and console state
   logic [tcw_pkg::ADDR_W-1:0]  win_base;
   logic [tcw_pkg::CELLS_W-1:0] win_cells;
   logic [7:0]                  win_attr;
   logic [tcw_pkg::ADDR_W-1:0]  cursor_q;
   logic [tcw_pkg::ADDR_W-1:0]  view_q;

   tcw_pkg::rsp_type pending_cells[$];
   int               errors;
   int               cycle_count;
   bit               idle_on;
   bit               hold_request;

   text_console_char_writer u_top (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   task automatic report_fault(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   // cursor and view update for one word, returns the expected response
   function automatic tcw_pkg::rsp_type console_step(input tcw_pkg::req_type w);
      tcw_pkg::rsp_type r;
      int unsigned      base_c;
      int unsigned      end_c;
      int unsigned      cur;
      int unsigned      ds;
      int unsigned      off;
      r      = '0;
      base_c = win_base;
      end_c  = base_c + win_cells;
      cur    = cursor_q;
      ds     = view_q;
      case (w.command)
         tcw_pkg::CMD_PUT: begin
            if (w.char_code == tcw_pkg::CH_NEWLINE) begin
               // a cursor below the base counts as being on the first line
               if (cur + tcw_pkg::LINE_WIDTH < end_c) begin
                  off = (cur >= base_c) ? cur - base_c : 0;
                  cur = (base_c + tcw_pkg::LINE_WIDTH * (off / tcw_pkg::LINE_WIDTH + 1))
                        & ADDR_MASK;
               end
            end else if (w.char_code == tcw_pkg::CH_BACKSPACE) begin
               if (cur > base_c) begin
                  cur            = cur - 1;
                  r.cell_write   = 1'b1;
                  r.cell_address = cur[tcw_pkg::ADDR_W-1:0];
                  r.cell_char    = tcw_pkg::CH_SPACE;
                  r.cell_attr    = win_attr;
               end
            end else if (cur + 1 < end_c) begin
               r.cell_write   = 1'b1;
               r.cell_address = cur[tcw_pkg::ADDR_W-1:0];
               r.cell_char    = w.char_code;
               r.cell_attr    = win_attr;
               cur            = (cur + 1) & ADDR_MASK;
            end
            // view follows the cursor a line at a time, stopped by the window end
            while (cur >= ds + tcw_pkg::SCREEN_CELLS && ds + tcw_pkg::SCREEN_CELLS < end_c)
               ds += tcw_pkg::LINE_WIDTH;
            ds = ds & ADDR_MASK;
         end
         tcw_pkg::CMD_BACK: begin
            if (ds > base_c)
               ds = (ds >= base_c + tcw_pkg::LINE_WIDTH) ? ds - tcw_pkg::LINE_WIDTH
                                                         : base_c;
         end
         tcw_pkg::CMD_FWD: begin
            if (ds + tcw_pkg::SCREEN_CELLS < end_c)
               ds = (ds + tcw_pkg::LINE_WIDTH) & ADDR_MASK;
         end
         default: begin
            cur = base_c;
            ds  = base_c;
         end
      endcase
      cursor_q      = cur[tcw_pkg::ADDR_W-1:0];
      view_q        = ds[tcw_pkg::ADDR_W-1:0];
      r.cursor_cell = cursor_q;
      r.view_start  = view_q;
      return r;
   endfunction

   // offer one word, hold it until taken, then predict its response
   task automatic send_word(input tcw_pkg::cmd_type cmd, input logic [7:0] ch);
      tcw_pkg::req_type w;
      w.command   = cmd;
      w.char_code = ch;
      while (idle_on && $urandom_range(0, 99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_cells.push_back(console_step(w));
   endtask

   // stop offering and wait for every outstanding response
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // all three window registers, one per cycle
   task automatic set_window(input logic [tcw_pkg::ADDR_W-1:0]  base,
                             input logic [tcw_pkg::CELLS_W-1:0] cells,
                             input logic [7:0]                  attr);
      csr_write_en <= 1'b1;
      csr_index    <= tcw_pkg::CSR_WINDOW_BASE;
      csr_wdata    <= tcw_pkg::CELLS_W'(base);
      @(posedge clock);
      csr_index    <= tcw_pkg::CSR_WINDOW_CELLS;
      csr_wdata    <= cells;
      @(posedge clock);
      csr_index    <= tcw_pkg::CSR_CHAR_ATTRIBUTE;
      csr_wdata    <= tcw_pkg::CELLS_W'(attr);
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      win_base  = base;
      win_cells = cells;
      win_attr  = attr;
   endtask

   function automatic logic [7:0] pick_put_char();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 22)
         return tcw_pkg::CH_NEWLINE;
      else if (roll < 30)
         return tcw_pkg::CH_BACKSPACE;
      return 8'($urandom_range(0, 255));
   endfunction

   // response side: check, then choose the next ready
   task automatic check_cell(input tcw_pkg::rsp_type got);
      tcw_pkg::rsp_type want;
      if (pending_cells.size() == 0) begin
         report_fault($sformatf("response word with nothing expected: %h", got));
      end else begin
         want = pending_cells.pop_front();
         if (got.cell_write !== want.cell_write)
            report_fault($sformatf("cell_write %0d, expected %0d",
                                   got.cell_write, want.cell_write));
         if (got.cell_address !== want.cell_address)
            report_fault($sformatf("cell_address %0d, expected %0d",
                                   got.cell_address, want.cell_address));
         if (got.cell_char !== want.cell_char)
            report_fault($sformatf("cell_char %h, expected %h",
                                   got.cell_char, want.cell_char));
         if (got.cell_attr !== want.cell_attr)
            report_fault($sformatf("cell_attr %h, expected %h",
                                   got.cell_attr, want.cell_attr));
         if (got.cursor_cell !== want.cursor_cell)
            report_fault($sformatf("cursor_cell %0d, expected %0d",
                                   got.cursor_cell, want.cursor_cell));
         if (got.view_start !== want.view_start)
            report_fault($sformatf("view_start %0d, expected %0d",
                                   got.view_start, want.view_start));
      end
   endtask

   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            check_cell(rsp_data);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(idle_on && $urandom_range(0, 99) < 6);
         end
      end
   end

   // reset values: printables, extreme bytes, backspace, newline, scrolls, home
   task automatic test_basic_editing();
      send_word(tcw_pkg::CMD_PUT, 8'h41);
      send_word(tcw_pkg::CMD_PUT, 8'h00);
      send_word(tcw_pkg::CMD_PUT, 8'hFF);
      send_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_BACKSPACE);
      send_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE);
      send_word(tcw_pkg::CMD_BACK, 8'hFF);
      send_word(tcw_pkg::CMD_FWD, 8'h00);
      send_word(tcw_pkg::CMD_BACK, 8'h55);
      send_word(tcw_pkg::CMD_HOME, 8'hAA);
      send_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_BACKSPACE);
      drain_results();
   endtask

   // one-line window above the cursor: newline from below the base,
   // the final cell, newline on the last line, scroll back at the base
   task automatic test_window_edges();
      set_window(14'd100, 15'd80, 8'hFF);
      send_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE);
      send_word(tcw_pkg::CMD_PUT, 8'h31);
      send_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_BACKSPACE);
      send_word(tcw_pkg::CMD_PUT, 8'h7A);
      send_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE);
      send_word(tcw_pkg::CMD_BACK, 8'h00);
      send_word(tcw_pkg::CMD_HOME, 8'h00);
      drain_results();
   endtask

   // top base: cursor, view and newline target wrap to 14 bits
   task automatic test_address_wrap();
      set_window(14'd16383, 15'd16320, 8'h00);
      send_word(tcw_pkg::CMD_HOME, 8'h00);
      send_word(tcw_pkg::CMD_PUT, 8'h7F);
      send_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE);
      send_word(tcw_pkg::CMD_FWD, 8'hFF);
      send_word(tcw_pkg::CMD_BACK, 8'hFF);
      drain_results();
   endtask

   // scroll back with the view below the base, and a follow stopped by the window end
   task automatic test_view_limits();
      set_window(14'd2050, 15'd16384, 8'h5A);
      send_word(tcw_pkg::CMD_BACK, 8'h0F);
      drain_results();
      set_window(14'd0, 15'd4000, 8'h07);
      send_word(tcw_pkg::CMD_HOME, 8'hF0);
      drain_results();
      set_window(14'd3040, 15'd80, 8'hA5);
      send_word(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE);
      send_word(tcw_pkg::CMD_FWD, 8'h00);
      drain_results();
   endtask

   // random words over a series of window settings
   task automatic test_random_traffic();
      logic [tcw_pkg::ADDR_W-1:0]  base;
      logic [tcw_pkg::CELLS_W-1:0] cells;
      logic [7:0]                  attr;
      int unsigned                 roll;
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: begin
               base  = '0;
               cells = 15'd80;
               attr  = 8'h00;
            end
            1: begin
               base  = 14'd16383;
               cells = 15'd16384;
               attr  = 8'hFF;
            end
            2: begin
               base  = '0;
               cells = 15'd16320;
               attr  = 8'($urandom_range(0, 255));
            end
            default: begin
               base  = $urandom_range(0, 1) ? 14'($urandom_range(0, 200))
                                            : 14'($urandom_range(0, 16383));
               cells = ($urandom_range(0, 2) == 0) ? 15'($urandom_range(1, 10) * 80)
                                                   : 15'($urandom_range(1, 204) * 80);
               attr  = 8'($urandom_range(0, 255));
            end
         endcase
         set_window(base, cells, attr);
         // one phase runs with no idling on either side
         idle_on = (phase != 5);
         if ($urandom_range(0, 1))
            send_word(tcw_pkg::CMD_HOME, 8'($urandom_range(0, 255)));
         repeat (150) begin
            roll = $urandom_range(0, 99);
            if (roll < 83)
               send_word(tcw_pkg::CMD_PUT, pick_put_char());
            else if (roll < 91)
               send_word(tcw_pkg::CMD_BACK, 8'($urandom_range(0, 255)));
            else if (roll < 99)
               send_word(tcw_pkg::CMD_FWD, 8'($urandom_range(0, 255)));
            else
               send_word(tcw_pkg::CMD_HOME, 8'($urandom_range(0, 255)));
         end
         drain_results();
      end
      idle_on = 1'b1;
   endtask

   // long response hold-off while words keep coming, then a full pause
   task automatic test_backpressure();
      set_window(14'd0, 15'd4000, 8'h07);
      send_word(tcw_pkg::CMD_HOME, 8'h00);
      hold_request = 1'b1;
      repeat (25) send_word(tcw_pkg::CMD_PUT, pick_put_char());
      drain_results();
   endtask

   initial begin
      errors       = 0;
      idle_on      = 1'b1;
      hold_request = 1'b0;
      reset        <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index    <= tcw_pkg::CSR_WINDOW_BASE;
      csr_wdata    <= '0;
      req_valid    <= 1'b0;
      req_data     <= '0;
      win_base     = tcw_pkg::BASE_RESET;
      win_cells    = tcw_pkg::CELLS_RESET;
      win_attr     = tcw_pkg::ATTR_RESET;
      cursor_q     = '0;
      view_q       = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_editing();
      test_window_edges();
      test_address_wrap();
      test_view_limits();
      test_random_traffic();
      test_backpressure();

      drain_results();
      repeat (40) @(posedge clock);
      if (pending_cells.size() != 0)
         report_fault($sformatf("%0d responses never arrived", pending_cells.size()));
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
